[rtl/eqd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_pkg: shared types, constants and helpers for the QRS detector
// Holds the result record, the register codes, the filter coefficients and the
// small arithmetic helpers used by the processing core.
// ----------------------------------------------------------------------------
package eqd_pkg;

	localparam int WINDOW_LENGTH_DEF = 54;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int EW      = 48;
	localparam int CFG_IW  = 4;
	localparam int CFG_DW  = 12;

	localparam logic [EW-1:0]     E48MAX = {EW{1'b1}};
	localparam logic [CFG_IW-1:0] CFG_REFRACTORY = 4'd0;
	localparam logic [CFG_IW-1:0] CFG_TIMEOUT    = 4'd1;
	localparam logic [11:0]       REFR_RESET     = 12'd72;
	localparam logic [11:0]       TMO_RESET      = 12'd1440;
	localparam logic [11:0]       AGE_MAX        = 12'd4095;

	typedef struct packed {
		logic               found;
		logic [11:0]        delay;
		logic signed [31:0] bp;
		logic [EW-1:0]      mean;
		logic [EW-1:0]      thr_i;
		logic [EW-1:0]      thr_f;
	} result_t;

	// Q2.16 biquad coefficients: b0, b1, b2, a1, a2 for the low-pass, then the high-pass.
	function automatic logic signed [17:0] coef(input logic hp, input logic [2:0] k);
		logic signed [17:0] c;
		case ({hp, k})
			4'b0000: c = 18'sd495;
			4'b0001: c = 18'sd990;
			4'b0010: c = 18'sd495;
			4'b0011: c = 18'sd56050;
			4'b0100: c = -18'sd25258;
			4'b1000: c = 18'sd31339;
			4'b1001: c = -18'sd62679;
			4'b1010: c = 18'sd31339;
			4'b1011: c = 18'sd62561;
			4'b1100: c = -18'sd30032;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// (new + 7 old) / 8, rounded down
	function automatic logic [EW-1:0] blend(input logic [EW-1:0] n, input logic [EW-1:0] o);
		logic [EW+2:0] s;
		s = {3'b0, n} + ({3'b0, o} << 3) - {3'b0, o};
		return s[EW+2:3];
	endfunction

	// (3 noise + signal) / 4, rounded down
	function automatic logic [EW-1:0] thresh(input logic [EW-1:0] sig, input logic [EW-1:0] noi);
		logic [EW+1:0] s;
		s = ({2'b0, noi} << 1) + {2'b0, noi} + {2'b0, sig};
		return s[EW+1:2];
	endfunction

endpackage
`default_nettype wire

[rtl/ecg_qrs_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_qrs_detector: QRS complex detector for an ECG sample stream
// Band-pass biquads, derivative, squared moving window and adaptive thresholds.
// ----------------------------------------------------------------------------
// The core takes one sample at a time and pops no new sample until the last
// result has been pushed, so a full result queue holds it back. Its pace comes
// from the single shared multiplier (five taps per biquad) and from the
// sixteen-bit-per-cycle reciprocal divider that forms the window mean.
// Reset clears all filter, window and level state at once; no clearing pass.
// ----------------------------------------------------------------------------
module ecg_qrs_detector #(
	parameter int WINDOW_LENGTH = eqd_pkg::WINDOW_LENGTH_DEF,
	parameter int FRACTION_BITS = eqd_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic signed [15:0]          sample,
	output logic                             empty,
	input  wire logic                        pop,
	output logic                             qrs_found,
	output logic [11:0]                      qrs_delay,
	output logic signed [31:0]               bandpass_value,
	output logic [47:0]                      integrated_value,
	output logic [47:0]                      integrated_threshold,
	output logic [47:0]                      filtered_threshold,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [eqd_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [eqd_pkg::CFG_DW-1:0]  cfg_data
);
	import eqd_pkg::*;

	// Front side: incoming sample beats wait here until the core is free.
	logic        smp_empty;
	logic [15:0] smp_data;
	logic        smp_pop;

	// Back side: finished results queue here so the core can move on.
	logic        res_full;
	logic        res_push;
	result_t     res_in;
	result_t     res_out;

	// The register file is always able to take a write beat.
	assign cfg_ready = 1'b1;

	eqd_fifo #(
		.WIDTH (16)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (sample),
		.pop     (smp_pop),
		.empty   (smp_empty),
		.rd_data (smp_data)
	);

	eqd_core #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_empty  (smp_empty),
		.in_sample (smp_data),
		.in_pop    (smp_pop),
		.out_full  (res_full),
		.out_push  (res_push),
		.out_data  (res_in)
	);

	eqd_fifo #(
		.WIDTH ($bits(result_t))
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_data (res_in),
		.pop     (pop),
		.empty   (empty),
		.rd_data (res_out)
	);

	// The oldest result fans out to one port per field.
	assign qrs_found            = res_out.found;
	assign qrs_delay            = res_out.delay;
	assign bandpass_value       = res_out.bp;
	assign integrated_value     = res_out.mean;
	assign integrated_threshold = res_out.thr_i;
	assign filtered_threshold   = res_out.thr_f;

endmodule
`default_nettype wire

[rtl/eqd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_fifo: two-entry queue
// Decouples a producer from a consumer; push and pop may both happen in one cycle.
// ----------------------------------------------------------------------------
module eqd_fifo #(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

[rtl/eqd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqd_core: sequenced QRS processing core
// Runs both biquads on one shared multiplier, the derivative, the moving window,
// a reciprocal divider for the window mean, and the adaptive level logic.
// ----------------------------------------------------------------------------
module eqd_core #(
	parameter int WINDOW_LENGTH = 54,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [eqd_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [eqd_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                        in_empty,
	input  wire logic [15:0]                 in_sample,
	output logic                             in_pop,
	input  wire logic                        out_full,
	output logic                             out_push,
	output eqd_pkg::result_t                 out_data
);
	import eqd_pkg::*;

	localparam int PW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int SUMW  = EW + PW;
	localparam int CH    = 16;
	localparam int NCH   = (SUMW + CH - 1) / CH;
	localparam int DW    = NCH * CH;
	localparam int VW    = PW + CH;
	localparam int SH    = VW + PW;
	localparam int MW    = VW + 1;
	localparam int SCW   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_MAC   = 12'b000000000010,
		ST_RES   = 12'b000000000100,
		ST_SQP   = 12'b000000001000,
		ST_PEAK  = 12'b000000010000,
		ST_DER   = 12'b000000100000,
		ST_SQD   = 12'b000001000000,
		ST_WIN   = 12'b000010000000,
		ST_DIV   = 12'b000100000000,
		ST_LEVEL = 12'b001000000000,
		ST_THR   = 12'b010000000000,
		ST_EMIT  = 12'b100000000000
	} state_t;

	state_t             state_q;
	logic [11:0]        refr_q;
	logic [11:0]        tmo_q;
	logic               sel_hp_q;
	logic [2:0]         cnt_q;
	logic signed [31:0] x_q;
	logic signed [31:0] lp_q;
	logic signed [31:0] bp_q;
	logic signed [31:0] lp_h_q [4];
	logic signed [31:0] hp_h_q [4];
	logic signed [31:0] dv_q [4];
	logic signed [55:0] acc_q;
	logic signed [63:0] prod_q;
	logic [31:0]        dmag_q;
	logic [EW-1:0]      win_mem [WINDOW_LENGTH];
	logic [EW-1:0]      rd_q;
	logic [WINDOW_LENGTH-1:0] valid_q;
	logic [PW-1:0]      pos_q;
	logic [SUMW-1:0]    sum_q;
	logic [DW-1:0]      dq_q;
	logic [PW-1:0]      rem_q;
	logic [SCW-1:0]     step_q;
	logic [EW-1:0]      mean_q;
	logic [EW-1:0]      last_mean_q;
	logic [EW-1:0]      peak_q;
	logic [EW-1:0]      sig_i_q, noi_i_q, thr_i_q, sig_f_q, noi_f_q, thr_f_q;
	logic [11:0]        age_q;
	logic [11:0]        since_q;
	logic               found_q;
	logic               upd_q;
	logic [11:0]        delay_q;

	logic signed [31:0] x_scaled;
	logic signed [31:0] mac_term;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [55:0] rnd;
	logic signed [31:0] y_sat;
	logic [63:0]        e_sh;
	logic [EW-1:0]      e_val;
	logic [31:0]        bp_mag;
	logic signed [63:0] d_full;
	logic signed [31:0] d_sat;
	logic [EW-1:0]      old_val;
	logic [SUMW-1:0]    sum_new;
	logic [VW-1:0]      dv_num;
	logic [VW+MW-1:0]   dv_prod;
	logic [CH-1:0]      dv_dig;
	logic [VW-1:0]      dv_back;
	logic [DW-1:0]      dq_nx;
	logic [PW-1:0]      rem_nx;
	logic               detect;

	assign x_scaled = $signed({{16{in_sample[15]}}, in_sample}) <<< FRACTION_BITS;
	assign in_pop   = (state_q == ST_IDLE) && !in_empty;
	assign out_push = (state_q == ST_EMIT) && !out_full;
	assign out_data = '{found_q, delay_q, bp_q, mean_q, thr_i_q, thr_f_q};

	// Multiply-accumulate operand for the current biquad term
	always_comb begin
		mac_term = 32'sd0;
		case (cnt_q)
			3'd0: mac_term = sel_hp_q ? lp_q : x_q;
			3'd1: mac_term = sel_hp_q ? hp_h_q[0] : lp_h_q[0];
			3'd2: mac_term = sel_hp_q ? hp_h_q[1] : lp_h_q[1];
			3'd3: mac_term = sel_hp_q ? hp_h_q[2] : lp_h_q[2];
			3'd4: mac_term = sel_hp_q ? hp_h_q[3] : lp_h_q[3];
			default: mac_term = 32'sd0;
		endcase
	end

	assign bp_mag = bp_q[31] ? (~bp_q + 32'd1) : bp_q;

	always_comb begin
		mul_a = 33'(mac_term);
		mul_b = 33'(coef(sel_hp_q, cnt_q));
		if (state_q == ST_SQP) begin
			mul_a = $signed({1'b0, bp_mag});
			mul_b = $signed({1'b0, bp_mag});
		end else if (state_q == ST_SQD) begin
			mul_a = $signed({1'b0, dmag_q});
			mul_b = $signed({1'b0, dmag_q});
		end
	end
	assign mul_p = mul_a * mul_b;

	assign rnd   = acc_q + 56'sd32768;
	assign y_sat = sat32(64'(rnd >>> 16));

	assign e_sh  = prod_q >> FRACTION_BITS;
	assign e_val = (|e_sh[63:EW]) ? E48MAX : e_sh[EW-1:0];

	assign d_full = (64'(bp_q) <<< 1) + 64'(dv_q[0]) - 64'(dv_q[2]) - (64'(dv_q[3]) <<< 1);
	assign d_sat  = sat32(d_full);

	assign old_val = valid_q[pos_q] ? rd_q : '0;
	assign sum_new = sum_q - SUMW'(old_val) + SUMW'(e_val);

	// One sixteen-bit quotient digit per cycle: the running remainder joined with
	// the next dividend chunk is divided by the window length through a scaled
	// reciprocal, exact for every numerator below the remainder bound.
	assign dv_num  = {rem_q, dq_q[DW-1 -: CH]};
	assign dv_prod = {{MW{1'b0}}, dv_num} * {{VW{1'b0}}, RECIP};
	assign dv_dig  = dv_prod[SH +: CH];
	assign dv_back = dv_num - VW'(dv_dig) * VW'(WINDOW_LENGTH);
	assign dq_nx   = {dq_q[DW-CH-1:0], dv_dig};
	assign rem_nx  = dv_back[PW-1:0];

	assign detect = (last_mean_q > thr_i_q) && (since_q > refr_q) && (peak_q > thr_f_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			refr_q      <= REFR_RESET;
			tmo_q       <= TMO_RESET;
			sel_hp_q    <= 1'b0;
			cnt_q       <= 3'd0;
			for (int i = 0; i < 4; i++) begin
				lp_h_q[i] <= 32'sd0;
				hp_h_q[i] <= 32'sd0;
				dv_q[i]   <= 32'sd0;
			end
			valid_q     <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			last_mean_q <= '0;
			peak_q      <= '0;
			sig_i_q     <= '0;
			noi_i_q     <= '0;
			thr_i_q     <= '0;
			sig_f_q     <= '0;
			noi_f_q     <= '0;
			thr_f_q     <= '0;
			age_q       <= 12'd0;
			since_q     <= 12'd0;
			step_q      <= '0;
			found_q     <= 1'b0;
			upd_q       <= 1'b0;
			delay_q     <= 12'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_REFRACTORY) refr_q <= cfg_data;
				else if (cfg_index == CFG_TIMEOUT) tmo_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (!in_empty) begin
						x_q      <= x_scaled;
						sel_hp_q <= 1'b0;
						cnt_q    <= 3'd0;
						acc_q    <= 56'sd0;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (cnt_q != 3'd5) prod_q <= mul_p[63:0];
					if (cnt_q != 3'd0) acc_q <= acc_q + prod_q[55:0];
					if (cnt_q == 3'd5) state_q <= ST_RES;
					cnt_q <= cnt_q + 3'd1;
				end
				ST_RES: begin
					cnt_q <= 3'd0;
					acc_q <= 56'sd0;
					if (!sel_hp_q) begin
						lp_h_q[1] <= lp_h_q[0];
						lp_h_q[0] <= x_q;
						lp_h_q[3] <= lp_h_q[2];
						lp_h_q[2] <= y_sat;
						lp_q      <= y_sat;
						sel_hp_q  <= 1'b1;
						state_q   <= ST_MAC;
					end else begin
						hp_h_q[1] <= hp_h_q[0];
						hp_h_q[0] <= lp_q;
						hp_h_q[3] <= hp_h_q[2];
						hp_h_q[2] <= y_sat;
						bp_q      <= y_sat;
						state_q   <= ST_SQP;
					end
				end
				ST_SQP: begin
					prod_q  <= mul_p[63:0];
					state_q <= ST_PEAK;
				end
				ST_PEAK: begin
					// A new larger peak restarts its age at one; otherwise its age is counted up below
					if (e_val > peak_q) begin
						peak_q <= e_val;
						age_q  <= 12'd1;
					end else if (age_q < AGE_MAX) begin
						age_q <= age_q + 12'd1;
					end
					if (since_q < tmo_q) begin
						since_q <= since_q + 12'd1;
					end else begin
						since_q <= 12'd0;
						for (int i = 0; i < 4; i++) begin
							lp_h_q[i] <= 32'sd0;
							hp_h_q[i] <= 32'sd0;
							dv_q[i]   <= 32'sd0;
						end
						valid_q <= '0;
						pos_q   <= '0;
						sum_q   <= '0;
					end
					state_q <= ST_DER;
				end
				ST_DER: begin
					dv_q[3] <= dv_q[2];
					dv_q[2] <= dv_q[1];
					dv_q[1] <= dv_q[0];
					dv_q[0] <= bp_q;
					dmag_q  <= d_sat[31] ? (~d_sat + 32'd1) : d_sat;
					state_q <= ST_SQD;
				end
				ST_SQD: begin
					prod_q  <= mul_p[63:0];
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					sum_q          <= sum_new;
					valid_q[pos_q] <= 1'b1;
					pos_q          <= (pos_q == PW'(WINDOW_LENGTH - 1)) ? '0 : pos_q + 1'b1;
					dq_q           <= DW'(sum_new);
					rem_q          <= '0;
					step_q         <= '0;
					state_q        <= ST_DIV;
				end
				ST_DIV: begin
					dq_q   <= dq_nx;
					rem_q  <= rem_nx;
					step_q <= step_q + 1'b1;
					if (step_q == SCW'(NCH - 1)) state_q <= ST_LEVEL;
				end
				ST_LEVEL: begin
					mean_q  <= dq_q[EW-1:0];
					found_q <= 1'b0;
					delay_q <= 12'd0;
					upd_q   <= 1'b0;
					if (dq_q[EW-1:0] > last_mean_q) begin
						last_mean_q <= dq_q[EW-1:0];
					end else begin
						if (detect) begin
							sig_f_q <= blend(peak_q, sig_f_q);
							sig_i_q <= blend(dq_q[EW-1:0], sig_i_q);
							since_q <= 12'd0;
							found_q <= 1'b1;
							delay_q <= age_q;
						end else begin
							noi_f_q <= blend(peak_q, noi_f_q);
							noi_i_q <= blend(dq_q[EW-1:0], noi_i_q);
						end
						upd_q       <= 1'b1;
						peak_q      <= '0;
						last_mean_q <= '0;
					end
					state_q <= ST_THR;
				end
				ST_THR: begin
					if (upd_q) begin
						thr_f_q <= thresh(sig_f_q, noi_f_q);
						thr_i_q <= thresh(sig_i_q, noi_i_q);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window store: read in the derivative step, written back in the window step
	always_ff @(posedge clk) begin
		if (state_q == ST_DER) rd_q <= win_mem[pos_q];
		if (state_q == ST_WIN) win_mem[pos_q] <= e_val;
	end

	ap_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < WINDOW_LENGTH)
		else $error("window position out of range");

	ap_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_full) |=> state_q == ST_IDLE)
		else $error("result pushed but sequencer did not return to idle");

	ap_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !found_q) |-> delay_q == 12'd0)
		else $error("non-zero delay without a detection");

	ap_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |=> (state_q == ST_MAC && !sel_hp_q && cnt_q == 3'd0))
		else $error("sample taken but low-pass did not start");

endmodule
`default_nettype wire

[dv/tb_ecg_qrs_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecg_qrs_detector: self-checking bench for the QRS detector
// Feeds synthetic heartbeat traces, noise bursts and extreme samples through
// the sample queue, predicts every result beat with a local fixed-point model
// of the filter chain and detection logic, and checks each popped beat field
// by field. Runs several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_ecg_qrs_detector;
	import eqd_pkg::*;

	localparam int WIN = 54;
	localparam int FB  = 8;
	localparam logic [47:0] ENERGY_CAP = 48'hFFFF_FFFF_FFFF;

	// Idling patterns for the sender and the receiver.
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic signed [15:0] sample = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic full, empty, cfg_ready;
	logic qrs_found;
	logic [11:0] qrs_delay;
	logic signed [31:0] bandpass_value;
	logic [47:0] integrated_value, integrated_threshold, filtered_threshold;

	ecg_qrs_detector dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop),
		.qrs_found(qrs_found), .qrs_delay(qrs_delay),
		.bandpass_value(bandpass_value), .integrated_value(integrated_value),
		.integrated_threshold(integrated_threshold), .filtered_threshold(filtered_threshold),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Samples waiting to be offered, and the results still owed by the block.
	logic signed [15:0] sample_backlog[$];
	result_t owed_results[$];

	idle_e idle_mode = IDLE_NONE;
	bit long_hold_go = 1'b0;
	int errors = 0;
	int samples_in = 0;
	int results_out = 0;
	int detections = 0;

	// ------------------------------------------------------------------------
	// Detector model state. The configuration copy is only changed while the
	// block is idle, so the driver can predict at the moment a beat is taken.
	// ------------------------------------------------------------------------
	logic [11:0] refractory_cfg, timeout_cfg;
	logic signed [31:0] lp_hist[4], hp_hist[4], diff_taps[4];
	logic [47:0] win_energy[WIN];
	int win_pos;
	longint unsigned win_total;
	logic [47:0] prev_mean, peak_hold;
	logic [47:0] sig_i, noi_i, thr_i, sig_f, noi_f, thr_f;
	int peak_age, since_qrs;

	function automatic void clear_filters();
		for (int k = 0; k < 4; k++) begin
			lp_hist[k] = '0;
			hp_hist[k] = '0;
			diff_taps[k] = '0;
		end
		for (int k = 0; k < WIN; k++) win_energy[k] = '0;
		win_pos = 0;
		win_total = 0;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// Squared value scaled back by the fraction bits, capped at 48 bits.
	function automatic logic [47:0] square_energy(input longint v);
		longint unsigned m, e;
		m = (v < 0) ? longint'(-v) : longint'(v);
		e = (m * m) >> FB;
		return (e > ENERGY_CAP) ? ENERGY_CAP : e[47:0];
	endfunction

	// One biquad section in Q2.16, rounded to nearest; hp selects the high-pass.
	function automatic logic signed [31:0] biquad_step(input bit hp, input logic signed [31:0] x);
		longint b0, b1, b2, a1, a2, acc;
		logic signed [31:0] h[4];
		logic signed [31:0] y;
		if (hp) begin
			b0 = 31339; b1 = -62679; b2 = 31339; a1 = 62561; a2 = -30032;
			h = hp_hist;
		end else begin
			b0 = 495; b1 = 990; b2 = 495; a1 = 56050; a2 = -25258;
			h = lp_hist;
		end
		acc = b0 * longint'(x) + b1 * longint'(h[0]) + b2 * longint'(h[1])
			+ a1 * longint'(h[2]) + a2 * longint'(h[3]);
		y = clip32((acc + 32768) >>> 16);
		h[1] = h[0];
		h[0] = x;
		h[3] = h[2];
		h[2] = y;
		if (hp) hp_hist = h;
		else lp_hist = h;
		return y;
	endfunction

	function automatic logic [47:0] level_blend(input logic [47:0] n, input logic [47:0] o);
		longint unsigned s;
		s = longint'(n) + 7 * longint'(o);
		return s[50:3];
	endfunction

	function automatic logic [47:0] level_threshold(input logic [47:0] sg, input logic [47:0] nz);
		longint unsigned s;
		s = 3 * longint'(nz) + longint'(sg);
		return s[49:2];
	endfunction

	function automatic void reset_detector_model();
		refractory_cfg = REFR_RESET;
		timeout_cfg = TMO_RESET;
		clear_filters();
		prev_mean = '0;
		peak_hold = '0;
		{sig_i, noi_i, thr_i, sig_f, noi_f, thr_f} = '0;
		peak_age = 0;
		since_qrs = 0;
	endfunction

	// Advances the model by one sample and returns the result beat it owes.
	function automatic result_t predict_qrs(input logic signed [15:0] s);
		result_t r;
		logic signed [31:0] x, lp, bp;
		logic [47:0] pe, sq, mean;
		longint d;
		bit candidate;
		r = '0;
		x = 32'(longint'(s) * (1 << FB));
		lp = biquad_step(1'b0, x);
		bp = biquad_step(1'b1, lp);
		pe = square_energy(longint'(bp));
		if (pe > peak_hold) begin
			peak_hold = pe;
			peak_age = 0;
		end
		if (peak_age < 4095) peak_age++;

		// Timeout restart: filters are wiped after this sample's filtering.
		if (since_qrs < timeout_cfg) begin
			since_qrs++;
		end else begin
			since_qrs = 0;
			clear_filters();
		end

		d = 2 * longint'(bp) + longint'(diff_taps[0]) - longint'(diff_taps[2])
			- 2 * longint'(diff_taps[3]);
		diff_taps[3] = diff_taps[2];
		diff_taps[2] = diff_taps[1];
		diff_taps[1] = diff_taps[0];
		diff_taps[0] = bp;
		sq = square_energy(longint'(clip32(d)));

		win_total = win_total - longint'(win_energy[win_pos]) + longint'(sq);
		win_energy[win_pos] = sq;
		win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
		mean = 48'(win_total / WIN);

		if (mean > prev_mean) begin
			prev_mean = mean;
		end else begin
			candidate = (prev_mean > thr_i) && (since_qrs > int'(refractory_cfg));
			if (candidate && peak_hold > thr_f) begin
				sig_f = level_blend(peak_hold, sig_f);
				sig_i = level_blend(mean, sig_i);
				since_qrs = 0;
				r.found = 1'b1;
				r.delay = 12'(peak_age);
			end else begin
				noi_f = level_blend(peak_hold, noi_f);
				noi_i = level_blend(mean, noi_i);
			end
			thr_f = level_threshold(sig_f, noi_f);
			thr_i = level_threshold(sig_i, noi_i);
			peak_hold = '0;
			prev_mean = '0;
		end
		r.bp = bp;
		r.mean = mean;
		r.thr_i = thr_i;
		r.thr_f = thr_f;
		return r;
	endfunction

	function automatic bit sender_rests();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 53;
			IDLE_BOTH:   return $urandom_range(0, 99) < 36;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 53;
			IDLE_BOTH:     return $urandom_range(0, 99) < 36;
			default:       return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset and the overall time limit.
	// ------------------------------------------------------------------------
	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sample driver. A beat is taken when push is high and full is low; the
	// model is stepped at that edge, then the next sample is offered unless the
	// sender decides to rest. Only one nonblocking write per signal per edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : sample_driver
		logic signed [15:0] taken;
		bit offer;
		if (arst_n) begin
			if (push && !full) begin
				taken = sample_backlog.pop_front();
				owed_results.push_back(predict_qrs(taken));
				samples_in++;
			end
			offer = (sample_backlog.size() != 0) && !sender_rests();
			push <= offer;
			if (sample_backlog.size() != 0) sample <= sample_backlog[0];
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor. Each popped beat is checked against the oldest owed
	// result. The long hold-off is counted here: pop stays low for hundreds of
	// cycles while the sender keeps offering, so the block must back up.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: mismatch on %s at result %0d: expected %0h, got %0h",
				$realtime, what, results_out, want, got);
	endtask

	int hold_left = 0;
	bit hold_served = 1'b0;

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					report_mismatch("unexpected result beat", '0, {63'b0, qrs_found});
				end else begin
					want = owed_results.pop_front();
					if (qrs_found !== want.found)
						report_mismatch("qrs_found", want.found, qrs_found);
					if (qrs_delay !== want.delay)
						report_mismatch("qrs_delay", want.delay, qrs_delay);
					if (bandpass_value !== want.bp)
						report_mismatch("bandpass_value", want.bp, bandpass_value);
					if (integrated_value !== want.mean)
						report_mismatch("integrated_value", want.mean, integrated_value);
					if (integrated_threshold !== want.thr_i)
						report_mismatch("integrated_threshold", want.thr_i,
							integrated_threshold);
					if (filtered_threshold !== want.thr_f)
						report_mismatch("filtered_threshold", want.thr_f,
							filtered_threshold);
					if (want.found) detections++;
				end
				results_out++;
			end
			if (long_hold_go && !hold_served) begin
				hold_served = 1'b1;
				hold_left = 700;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !receiver_stalls();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: synthetic heart rhythm. Most of it is beats (a triangular QRS
	// spike of random height, width and polarity on a noisy baseline, at a
	// random rate), the rest is bursts of raw random samples.
	// ------------------------------------------------------------------------
	task automatic add_rhythm(input int n);
		int left, period, width, amp, nz, pos, v;
		bit flip;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 12) begin
				repeat ($urandom_range(5, 30)) begin
					if (left > 0) begin
						sample_backlog.push_back(16'($urandom));
						left--;
					end
				end
			end else begin
				period = $urandom_range(40, 220);
				width = $urandom_range(3, 12);
				amp = $urandom_range(1500, 32767);
				nz = $urandom_range(0, 600);
				flip = $urandom_range(0, 3) == 0;
				for (pos = 0; pos < period && left > 0; pos++) begin
					v = 0;
					if (pos < width) v = amp * pos / width;
					else if (pos < 2 * width) v = amp * (2 * width - pos) / width;
					if (flip) v = -v;
					v = v + int'($urandom_range(0, 2 * nz)) - nz;
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
					sample_backlog.push_back(16'(v));
					left--;
				end
			end
		end
	endtask

	// Waits until every sample is taken and every result checked, then lets
	// the core settle for longer than its latency.
	task automatic drain();
		while (sample_backlog.size() != 0 || owed_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_REFRACTORY) refractory_cfg = val;
		else if (idx == CFG_TIMEOUT) timeout_cfg = val;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [11:0] refr, input logic [11:0] tmo,
			input idle_e mode, input int n);
		drain();
		write_register(CFG_REFRACTORY, refr);
		write_register(CFG_TIMEOUT, tmo);
		idle_mode = mode;
		add_rhythm(n);
	endtask

	initial begin
		reset_detector_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at reset settings: field extremes, alternating bit
		// patterns and full-scale steps.
		sample_backlog.push_back(16'sh8000);
		sample_backlog.push_back(16'sh7fff);
		sample_backlog.push_back(16'sh0000);
		sample_backlog.push_back(16'shffff);
		sample_backlog.push_back(16'sh0001);
		sample_backlog.push_back(16'sh5555);
		sample_backlog.push_back(16'shaaaa);
		repeat (8) sample_backlog.push_back(16'sh7fff);
		repeat (8) sample_backlog.push_back(16'sh8000);
		add_rhythm(120);

		// Shortest refractory with the longest timeout.
		run_phase(12'd0, 12'd4095, IDLE_SENDER, 200);
		// Longest refractory with a restart on every second sample; an index
		// beyond the register list must be ignored.
		drain();
		write_register(4'd7, 12'hfff);
		run_phase(12'd4095, 12'd1, IDLE_RECEIVER, 150);
		// Zero timeout: a restart on every sample.
		run_phase(12'd20, 12'd0, IDLE_BOTH, 150);

		// Receiver holds off for a long stretch while samples keep coming.
		run_phase(12'd40, 12'd300, IDLE_NONE, 150);
		long_hold_go = 1'b1;

		run_phase(12'd72, 12'd1440, IDLE_BOTH, 150);
		run_phase(12'd10, 12'd200, IDLE_SENDER, 150);
		drain();

		$display("Checked %0d samples and %0d result beats, %0d of them QRS detections,",
			samples_in, results_out, detections);
		$display("over six register settings including zero timeout and both extremes.");
		if (errors == 0 && owed_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
